FILE: src/erp_pkg.sv
`default_nettype none
package erp_pkg;
  localparam int MaxStops = 256;
  localparam int StopW = $clog2(MaxStops);
  localparam int RouteCap = 256;
  localparam int PosW = 8;
  localparam int LenW = 9;
  localparam int CostW = 48;
  localparam int CntW = 10;
  localparam logic [CostW-1:0] Sat48 = {CostW{1'b1}};

  typedef enum logic [1:0] {
    OP_COST  = 2'd0,
    OP_ROUTE = 2'd1,
    OP_SCORE = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_RD,
    ST_LK,
    ST_CELL,
    ST_DIV,
    ST_DONE
  } state_t;

  // request from sequencer to the divider
  typedef struct packed {
    logic             start;
    logic [CostW-1:0] dividend;
    logic [CntW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CostW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [CostW-1:0] sat_add(input logic [CostW-1:0] a,
                                               input logic [CostW-1:0] b);
    logic [CostW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostW] ? Sat48 : s[CostW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: src/erp_div.sv
`default_nettype none
module erp_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire erp_pkg::div_req_t req,
  output erp_pkg::div_rsp_t      rsp
);
  import erp_pkg::*;

  logic [CostW-1:0] quo_r;
  logic [CntW-1:0]  rem_r;
  logic [CntW-1:0]  dvs_r;
  logic [5:0]       cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [CntW:0]    trial;

  // one quotient bit per cycle, restoring
  assign trial = {rem_r, quo_r[CostW-1]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(CostW);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        if (!trial[CntW]) begin
          rem_r <= trial[CntW-1:0];
          quo_r <= {quo_r[CostW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[CntW-2:0], quo_r[CostW-1]};
          quo_r <= {quo_r[CostW-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> busy_r) else $error("divider did not start");
endmodule
`default_nettype wire

FILE: src/erp_edit_distance_per_edit.sv
`default_nettype none
// channel  | ports                                       | handshake
// in       | in_op/row_index/col_index/cost/position/... | start & !busy
// out      | out_total_cost/edit_count/cost_per_edit     | out_valid, one cycle
// cfg      | cfg_gap_penalty                             | cfg_valid & cfg_ready
// load items are written on acceptance; busy stays low.
// a score item holds busy through len+1 base-row writes, a setup step per row,
// three steps per cell (route and row read, cost memory read, shared
// add/compare), then a bit-serial divide and a step each to collect the
// quotient and finish; when len is 0 it goes from the base row straight to finish.
// out_valid rises in the first cycle that busy is low again.
// reset is synchronous, active low; memories are not cleared.
// results cannot be stalled; out_valid is high for exactly one cycle.
module erp_edit_distance_per_edit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_op,
  input  wire logic [7:0]  in_row_index,
  input  wire logic [7:0]  in_col_index,
  input  wire logic [31:0] in_cost,
  input  wire logic [7:0]  in_position,
  input  wire logic [7:0]  in_actual_stop,
  input  wire logic [7:0]  in_sub_stop,
  input  wire logic [8:0]  in_route_len,
  output logic             out_valid,
  output logic [47:0]      out_total_cost,
  output logic [9:0]       out_edit_count,
  output logic [47:0]      out_cost_per_edit,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_gap_penalty
);
  import erp_pkg::*;

  // memories
  logic [31:0]      cost_mem [MaxStops*MaxStops];
  logic [7:0]       act_mem  [RouteCap];
  logic [7:0]       sub_mem  [RouteCap];
  logic [CostW-1:0] dpc_mem  [RouteCap+1];
  logic [CntW-1:0]  dpn_mem  [RouteCap+1];

  state_t state_r, state_nxt;
  logic [31:0]      gap_r;
  logic [LenW-1:0]  len_r, i_r, j_r;
  logic [CostW-1:0] gi_r;            // i*gap (j*gap during the base row), built by repeated add
  logic [7:0]       ha_r, hs_r;
  logic [CostW-1:0] diag_c_r, left_c_r, up_c_r;
  logic [CntW-1:0]  diag_n_r, left_n_r, up_n_r;
  logic [CostW-1:0] tot_r;
  logic [CntW-1:0]  cnt_r;
  logic [CostW-1:0] cpe_r;
  logic             ov_r;
  logic [7:0]       ha_rd, hs_rd;
  logic [CostW-1:0] up_c_rd;
  logic [CntW-1:0]  up_n_rd;
  logic [31:0]      lk_rd;
  div_req_t         dreq;
  div_rsp_t         drsp;

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) gap_r <= 32'd65536000;
    else if (cfg_valid && cfg_ready) gap_r <= cfg_gap_penalty;
  end

  // loads
  always_ff @(posedge clk) begin
    if (accept && op_t'(in_op) == OP_COST)
      cost_mem[{in_row_index, in_col_index}] <= in_cost;
    if (accept && op_t'(in_op) == OP_ROUTE) begin
      act_mem[in_position] <= in_actual_stop;
      sub_mem[in_position] <= in_sub_stop;
    end
  end

  // registered route and row reads, cost lookup from the fresh route data
  logic [PosW-1:0] ra_a, ra_s;
  assign ra_a = PosW'(len_r - i_r);
  assign ra_s = PosW'(len_r - j_r);
  always_ff @(posedge clk) begin
    ha_rd   <= act_mem[ra_a];
    hs_rd   <= sub_mem[ra_s];
    up_c_rd <= dpc_mem[j_r];
    up_n_rd <= dpn_mem[j_r];
    lk_rd   <= cost_mem[{ha_rd, hs_rd}];
  end

  // shared add/compare unit
  logic [CostW-1:0] o1, o2, o3, rc;
  logic [CntW-1:0]  rn;
  logic [CostW-1:0] gapw;
  assign gapw = {16'd0, gap_r};
  assign o1 = sat_add(diag_c_r, {16'd0, lk_rd});
  assign o2 = sat_add(up_c_r, gapw);
  assign o3 = sat_add(left_c_r, gapw);
  always_comb begin
    if (o1 < o2 && o1 < o3) begin
      rc = o1;
      rn = diag_n_r + ((ha_r == hs_r) ? CntW'(0) : CntW'(1));
    end else if (o2 < o3) begin
      rc = o2;
      rn = up_n_r + CntW'(1);
    end else begin
      rc = o3;
      rn = left_n_r + CntW'(1);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept && op_t'(in_op) == OP_SCORE) state_nxt = ST_INIT;
      ST_INIT: if (j_r == len_r) state_nxt = (len_r == '0) ? ST_DONE : ST_ROW;
      ST_ROW:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LK;
      ST_LK:   state_nxt = ST_CELL;
      ST_CELL: begin
        if (j_r != len_r) state_nxt = ST_RD;
        else if (i_r != len_r) state_nxt = ST_ROW;
        else state_nxt = ST_DIV;
      end
      ST_DIV:  if (drsp.done) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == ST_DONE);
    end
    case (state_r)
      ST_IDLE: begin
        len_r <= (in_route_len > LenW'(RouteCap)) ? LenW'(RouteCap) : in_route_len;
        j_r   <= '0;
        i_r   <= '0;
        gi_r  <= '0;
      end
      ST_INIT: begin
        // base row j*gap, j
        dpc_mem[j_r] <= gi_r;
        dpn_mem[j_r] <= CntW'(j_r);
        j_r  <= j_r + LenW'(1);
        if (j_r == len_r) begin
          i_r  <= '0;
          gi_r <= '0;
          tot_r <= '0;
          cnt_r <= '0;
        end else begin
          gi_r <= sat_add(gi_r, gapw);
        end
      end
      ST_ROW: begin
        diag_c_r <= dpc_mem[0];
        diag_n_r <= dpn_mem[0];
        left_c_r <= sat_add(gi_r, gapw);
        left_n_r <= CntW'(i_r + LenW'(1));
        dpc_mem[0] <= sat_add(gi_r, gapw);
        dpn_mem[0] <= CntW'(i_r + LenW'(1));
        gi_r <= sat_add(gi_r, gapw);
        i_r  <= i_r + LenW'(1);
        j_r  <= LenW'(1);
      end
      ST_LK: begin
        // route heads and upper cell are ready, cost lookup issues now
        ha_r <= ha_rd;
        hs_r <= hs_rd;
        up_c_r <= up_c_rd;
        up_n_r <= up_n_rd;
      end
      ST_CELL: begin
        dpc_mem[j_r] <= rc;
        dpn_mem[j_r] <= rn;
        left_c_r <= rc;
        left_n_r <= rn;
        diag_c_r <= up_c_r;
        diag_n_r <= up_n_r;
        j_r <= j_r + LenW'(1);
        tot_r <= rc;
        cnt_r <= rn;
      end
      ST_DIV: if (drsp.done) cpe_r <= drsp.quotient;
      ST_DONE: if (len_r == '0) cpe_r <= '0;
      default: ;
    endcase
  end

  // divider runs after the last cell; a zero count is masked at the output
  assign dreq.start    = (state_r == ST_CELL) && (state_nxt == ST_DIV);
  assign dreq.dividend = rc;
  assign dreq.divisor  = rn;

  erp_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  logic [CostW-1:0] cpe_out;
  assign cpe_out = (cnt_r == '0) ? '0 : cpe_r;

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE) begin
      out_total_cost    <= tot_r;
      out_edit_count    <= cnt_r;
      out_cost_per_edit <= cpe_out;
    end
  end
  assign out_valid = ov_r;

  a_valid_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == ST_DONE)) else $error("result without done");
  a_busy_no_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |-> busy) else $error("cell step while idle");
  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CELL) |-> (j_r <= len_r && j_r != '0)) else $error("column out of range");
endmodule
`default_nettype wire
